FILE: hw/rtl/c2s_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the spherical converter.
package c2s_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int CORDIC_STAGES_DEF = 32;

    // Coordinates are scaled so that the CORDIC datapath sees 60-bit values.
    localparam int SCALED_W = 60;
    localparam int DP_W     = 64;
    localparam int RHO_IN_W = 2 * SCALED_W;
    localparam int RHO_W    = SCALED_W;

    // Angle accumulator, radians with 32 fraction bits.
    localparam int ZW = 40;

    localparam int RADIUS_W = 32;
    localparam int AZ_W     = 32;
    localparam int POLAR_W  = 31;
    localparam int OUT_TDATA_W = ((RADIUS_W + AZ_W + POLAR_W + 7) / 8) * 8;

    typedef logic signed [DP_W-1:0] t_dp;
    typedef logic signed [ZW-1:0]   t_ang;

    localparam t_ang PI_Q32 = 40'sd13493037705;
    localparam t_ang PI_Q29 = 40'sd1686629713;

    localparam t_ang ATAN_HEAD [11] = '{
        40'sd3373259426, 40'sd1991351318, 40'sd1052175346, 40'sd534100635,
        40'sd268086748,  40'sd134174063,  40'sd67103403,   40'sd33553749,
        40'sd16777131,   40'sd8388597,    40'sd4194303
    };

    // atan(2^-i) in Q.32; beyond the table the angle equals 2^-i
    function automatic t_ang atan_step(input int unsigned i);
        t_ang v;
        v = '0;
        if (i < 11) begin
            v = ATAN_HEAD[i[3:0]];
        end else if (i <= 32) begin
            v = ZW'(64'd1 << (32 - i));
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/c2s_isqrt.sv
// Pipelined integer square root, one root bit per stage, with remainder and side payload.
module c2s_isqrt #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [IN_W-1:0]       i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [IN_W/2-1:0]     o_root,
    output logic [IN_W/2+1:0]     o_rem,
    output logic [SIDE_W-1:0]     o_side
);
    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 2;

    logic              r_v    [OUT_W];
    logic [IN_W-1:0]   r_rad  [OUT_W];
    logic [OUT_W-1:0]  r_root [OUT_W];
    logic [RW-1:0]     r_rem  [OUT_W];
    logic [SIDE_W-1:0] r_side [OUT_W];

    logic [IN_W-1:0]   p_rad  [OUT_W];
    logic [OUT_W-1:0]  p_root [OUT_W];
    logic [RW-1:0]     p_rem  [OUT_W];

    logic [IN_W-1:0]   n_rad  [OUT_W];
    logic [OUT_W-1:0]  n_root [OUT_W];
    logic [RW-1:0]     n_rem  [OUT_W];

    always_comb begin
        logic [RW-1:0] t_rem;
        logic [RW-1:0] trial;
        logic          ge;
        p_rad[0]  = i_rad;
        p_root[0] = '0;
        p_rem[0]  = '0;
        for (int k = 1; k < OUT_W; k++) begin
            p_rad[k]  = r_rad[k-1];
            p_root[k] = r_root[k-1];
            p_rem[k]  = r_rem[k-1];
        end
        for (int k = 0; k < OUT_W; k++) begin
            // bring down two radicand bits, try root bit one
            t_rem     = {p_rem[k][RW-3:0], p_rad[k][IN_W-1 -: 2]};
            trial     = {p_root[k], 2'b01};
            ge        = (t_rem >= trial);
            n_rem[k]  = ge ? (t_rem - trial) : t_rem;
            n_root[k] = {p_root[k][OUT_W-2:0], ge};
            n_rad[k]  = {p_rad[k][IN_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < OUT_W; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < OUT_W; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < OUT_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < OUT_W; k++) begin
                r_rad[k]  <= n_rad[k];
                r_root[k] <= n_root[k];
                r_rem[k]  <= n_rem[k];
            end
        end
    end

    assign o_valid = r_v[OUT_W-1];
    assign o_root  = r_root[OUT_W-1];
    assign o_rem   = r_rem[OUT_W-1];
    assign o_side  = r_side[OUT_W-1];

endmodule

FILE: hw/rtl/c2s_cordic.sv
// Two-lane pipelined vectoring CORDIC: angle of each (x, y) lane, one stage per rotation.
module c2s_cordic #(
    parameter int STAGES = c2s_pkg::CORDIC_STAGES_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  c2s_pkg::t_dp         i_x [2],
    input  c2s_pkg::t_dp         i_y [2],
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output c2s_pkg::t_ang        o_ang [2],
    output logic [SIDE_W-1:0]    o_side
);
    import c2s_pkg::*;

    localparam int NS = STAGES + 1;

    logic              r_v    [NS];
    logic [SIDE_W-1:0] r_side [NS];
    t_dp               r_x    [NS][2];
    t_dp               r_y    [NS][2];
    t_ang              r_z    [NS][2];

    t_dp               n_x    [NS][2];
    t_dp               n_y    [NS][2];
    t_ang              n_z    [NS][2];

    always_comb begin
        t_dp  px;
        t_dp  py;
        t_ang pz;
        for (int l = 0; l < 2; l++) begin
            // left half plane: flip by pi first
            if (i_x[l] < 0) begin
                n_x[0][l] = -i_x[l];
                n_y[0][l] = -i_y[l];
                n_z[0][l] = (i_y[l] >= 0) ? PI_Q32 : -PI_Q32;
            end else begin
                n_x[0][l] = i_x[l];
                n_y[0][l] = i_y[l];
                n_z[0][l] = '0;
            end
            for (int k = 1; k < NS; k++) begin
                px = r_x[k-1][l];
                py = r_y[k-1][l];
                pz = r_z[k-1][l];
                n_x[k][l] = px;
                n_y[k][l] = py;
                n_z[k][l] = pz;
                if (py > 0) begin
                    n_x[k][l] = px + (py >>> (k - 1));
                    n_y[k][l] = py - (px >>> (k - 1));
                    n_z[k][l] = pz + atan_step(k - 1);
                end else if (py < 0) begin
                    n_x[k][l] = px - (py >>> (k - 1));
                    n_y[k][l] = py + (px >>> (k - 1));
                    n_z[k][l] = pz - atan_step(k - 1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < NS; k++) begin
                for (int l = 0; l < 2; l++) begin
                    r_x[k][l] <= n_x[k][l];
                    r_y[k][l] <= n_y[k][l];
                    r_z[k][l] <= n_z[k][l];
                end
            end
        end
    end

    assign o_valid  = r_v[NS-1];
    assign o_ang[0] = r_z[NS-1][0];
    assign o_ang[1] = r_z[NS-1][1];
    assign o_side   = r_side[NS-1];

endmodule

FILE: hw/rtl/cartesian_to_spherical.sv
// Cartesian to spherical converter: radius, azimuth and polar angle of one point per cycle while not held.
//
// Takes one point (x, y, z) in signed Q16.16 per request and returns radius (unsigned
// Q16.16, rounded, saturated), azimuth atan2(y, x) in radians as signed Q3.29 and polar
// angle acos(z / r) in radians as unsigned Q2.29, both rounded to nearest. The polar angle
// reads zero while i_cfg_wdata last wrote 0 (two-dimensional data) and at the origin;
// reset selects three-dimensional data. A new point is taken every clock cycle but while
// the pipeline holds; results leave in order through stages 1 to 3, the bit-per-stage
// square roots for rho and radius, stage 4, the CORDIC stage chain and the output
// register. The pipeline holds, with o_s_tready low, while a result waits untaken.
// Write the mode register only while no point is in flight.
module cartesian_to_spherical #(
    parameter int COORD_WIDTH   = c2s_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    // slave side: x_coord, y_coord, z_coord from bit 0 up, zero padded
    input  logic                                         i_s_tvalid,
    output logic                                         o_s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]           i_s_tdata,
    // master side: radius, azimuth, polar_angle from bit 0 up, zero padded
    output logic                                         o_m_tvalid,
    input  logic                                         i_m_tready,
    output logic [c2s_pkg::OUT_TDATA_W-1:0]              o_m_tdata,
    // mode register: three_d_mode
    input  logic                                         i_cfg_we,
    input  logic                                         i_cfg_wdata
);
    import c2s_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int G     = SCALED_W - W;     // guard shift into the CORDIC datapath
    localparam int LO    = W / 2;            // low half of each magnitude
    localparam int HI    = W - LO;
    localparam int SAT_W = (W + 1 > 33) ? W + 1 : 33;
    localparam int RHO_SIDE_W = 5 * W;
    localparam int RAD_SIDE_W = 3 * W + RHO_W;

    logic en;
    logic r_three_d;

    // ---- stage 1: magnitudes split into halves, partial products
    logic signed [W-1:0] c_in  [3];
    logic [W-1:0]        c_mag [3];
    logic                r1_v;
    logic signed [W-1:0] r1_c  [3];
    logic [2*HI-1:0]     r1_aa [3];
    logic [HI+LO-1:0]    r1_ab [3];
    logic [2*LO-1:0]     r1_bb [3];

    // ---- stage 2: squares
    logic                r2_v;
    logic signed [W-1:0] r2_c  [3];
    logic [2*W-1:0]      r2_sq [3];

    // ---- stage 3: x^2 + y^2 and full sum
    logic                r3_v;
    logic signed [W-1:0] r3_c  [3];
    logic [2*W-1:0]      r3_sxy;
    logic [2*W-1:0]      r3_s;

    // ---- rho root
    logic                  rho_v;
    logic [RHO_W-1:0]      rho_root;
    logic [RHO_SIDE_W-1:0] rho_side;

    // ---- radius root
    logic                  rad_v;
    logic [W-1:0]          rad_root;
    logic [W+1:0]          rad_rem;
    logic [RAD_SIDE_W-1:0] rad_side;

    // ---- stage 4: rounded radius, scaled CORDIC operands
    logic                r4_v;
    logic [RADIUS_W-1:0] r4_radius;
    t_dp                 r4_x [2];
    t_dp                 r4_y [2];

    logic signed [W-1:0] s4_x;
    logic signed [W-1:0] s4_y;
    logic signed [W-1:0] s4_z;
    logic [RHO_W-1:0]    s4_rho;
    logic [W:0]          s4_full;
    logic [SAT_W-1:0]    s4_ext;
    logic [RADIUS_W-1:0] n4_radius;

    // ---- CORDIC
    logic                cor_v;
    t_ang                cor_ang [2];
    logic [RADIUS_W-1:0] cor_radius;

    // ---- output
    logic                r_out_v;
    logic [RADIUS_W-1:0] r_out_radius;
    logic [AZ_W-1:0]     r_out_az;
    logic [POLAR_W-1:0]  r_out_polar;
    t_ang                q_az;
    t_ang                q_pol;
    t_ang                n_az;
    t_ang                n_pol;

    // whole pipe advances unless the output holds an untaken result
    assign en         = !r_out_v || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_d <= 1'b1;
        end else if (i_cfg_we) begin
            r_three_d <= i_cfg_wdata;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            c_in[c]  = $signed(i_s_tdata[c*W +: W]);
            c_mag[c] = c_in[c][W-1] ? W'(-c_in[c]) : W'(c_in[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= rad_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r1_c[c]  <= c_in[c];
                r1_aa[c] <= c_mag[c][W-1:LO] * c_mag[c][W-1:LO];
                r1_ab[c] <= c_mag[c][W-1:LO] * c_mag[c][LO-1:0];
                r1_bb[c] <= c_mag[c][LO-1:0] * c_mag[c][LO-1:0];
                r2_c[c]  <= r1_c[c];
                r2_sq[c] <= ((2*W)'(r1_aa[c]) << (2*LO))
                          + ((2*W)'(r1_ab[c]) << (LO + 1))
                          + (2*W)'(r1_bb[c]);
                r3_c[c]  <= r2_c[c];
            end
            r3_sxy <= r2_sq[0] + r2_sq[1];
            r3_s   <= r2_sq[0] + r2_sq[1] + r2_sq[2];
        end
    end

    // rho = floor sqrt((x^2 + y^2) at the CORDIC scale)
    c2s_isqrt #(
        .IN_W   (RHO_IN_W),
        .SIDE_W (RHO_SIDE_W)
    ) u_rho (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_rad   ({r3_sxy, {(2*G){1'b0}}}),
        .i_side  ({r3_c[0], r3_c[1], r3_c[2], r3_s}),
        .o_valid (rho_v),
        .o_root  (rho_root),
        .o_rem   (),
        .o_side  (rho_side)
    );

    // radius root; remainder drives round half up
    c2s_isqrt #(
        .IN_W   (2 * W),
        .SIDE_W (RAD_SIDE_W)
    ) u_radius (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rho_v),
        .i_rad   (rho_side[2*W-1:0]),
        .i_side  ({rho_side[RHO_SIDE_W-1:2*W], rho_root}),
        .o_valid (rad_v),
        .o_root  (rad_root),
        .o_rem   (rad_rem),
        .o_side  (rad_side)
    );

    always_comb begin
        s4_rho = rad_side[RHO_W-1:0];
        s4_z   = $signed(rad_side[RHO_W +: W]);
        s4_y   = $signed(rad_side[RHO_W + W +: W]);
        s4_x   = $signed(rad_side[RHO_W + 2*W +: W]);
        // s > r^2 + r exactly when remainder exceeds the root
        s4_full = {1'b0, rad_root} + (W+1)'(rad_rem > {2'b00, rad_root});
        s4_ext  = SAT_W'(s4_full);
        if (s4_ext > SAT_W'(33'h0_FFFF_FFFF)) begin
            n4_radius = '1;
        end else begin
            n4_radius = s4_ext[RADIUS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_radius <= n4_radius;
            r4_x[0]   <= $signed({{(DP_W-SCALED_W){s4_x[W-1]}}, s4_x, {G{1'b0}}});
            r4_y[0]   <= $signed({{(DP_W-SCALED_W){s4_y[W-1]}}, s4_y, {G{1'b0}}});
            r4_x[1]   <= $signed({{(DP_W-SCALED_W){s4_z[W-1]}}, s4_z, {G{1'b0}}});
            r4_y[1]   <= $signed({{(DP_W-RHO_W){1'b0}}, s4_rho});
        end
    end

    // lane 0: azimuth atan2(y, x); lane 1: polar atan2(rho, z)
    c2s_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (RADIUS_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_x     (r4_x),
        .i_y     (r4_y),
        .i_side  (r4_radius),
        .o_valid (cor_v),
        .o_ang   (cor_ang),
        .o_side  (cor_radius)
    );

    // round Q.32 to Q3.29 half up, clamp azimuth to +-pi and polar angle to 0..pi
    always_comb begin
        q_az  = (cor_ang[0] + t_ang'(4)) >>> 3;
        q_pol = (cor_ang[1] + t_ang'(4)) >>> 3;
        n_az  = q_az;
        if (q_az > PI_Q29) begin
            n_az = PI_Q29;
        end else if (q_az < -PI_Q29) begin
            n_az = -PI_Q29;
        end
        n_pol = q_pol;
        if (!r_three_d || q_pol < 0) begin
            n_pol = '0;
        end else if (q_pol > PI_Q29) begin
            n_pol = PI_Q29;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= cor_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_radius <= cor_radius;
            r_out_az     <= n_az[AZ_W-1:0];
            r_out_polar  <= n_pol[POLAR_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_polar, r_out_az, r_out_radius});

endmodule

FILE: tb/sv/c2s_checker.sv
`timescale 1ns / 1ps
// Checker for the spherical converter: predicts each point's result and compares in order.
module c2s_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [95:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        logic [30:0] polar;
        logic [31:0] azimuth;
        logic [31:0] radius;
    } t_sph;

    t_sph sph_q[$];
    logic mode_3d;

    function automatic logic [63:0] floor_root(input logic [127:0] v);
        logic [63:0] r, t;
        r = '0;
        for (int b = 61; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= v) r = t;
        end
        return r;
    endfunction

    function automatic longint vector_angle(input longint x, input longint y);
        longint a, dx, dy, st;
        a = 0;
        if (x < 0) begin
            a = (y >= 0) ? longint'(c2s_pkg::PI_Q32) : -longint'(c2s_pkg::PI_Q32);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < c2s_pkg::CORDIC_STAGES_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (i < 11) st = longint'(c2s_pkg::ATAN_HEAD[i]);
            else if (i <= 32) st = longint'(64'd1 << (32 - i));
            else st = 0;
            // a residual of exactly zero freezes the stage
            if (y > 0) begin
                x += dx; y -= dy; a += st;
            end else if (y < 0) begin
                x -= dx; y += dy; a -= st;
            end
        end
        return a;
    endfunction

    function automatic longint round_q29(input longint a);
        longint r, lim;
        lim = longint'(c2s_pkg::PI_Q29);
        r = (a + 4) >>> 3;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_sph predict_sph(input logic [95:0] d, input logic m3);
        longint x, y, z, az, pol;
        logic [127:0] sxy, sall, rr;
        logic [63:0] r, rho;
        t_sph o;
        x = longint'($signed(d[31:0]));
        y = longint'($signed(d[63:32]));
        z = longint'($signed(d[95:64]));
        sxy = 128'(x * x) + 128'(y * y);
        sall = sxy + 128'(z * z);
        r = floor_root(sall);
        rr = {64'd0, r} * {64'd0, r} + {64'd0, r};
        if (sall > rr) r++;
        o.radius = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
        az = 0;
        if (x != 0 || y != 0) az = round_q29(vector_angle(x <<< 28, y <<< 28));
        o.azimuth = az[31:0];
        pol = 0;
        if (m3 && sall != 0) begin
            rho = floor_root(sxy << 56);
            pol = round_q29(vector_angle(z <<< 28, longint'(rho)));
            if (pol < 0) pol = 0;
        end
        o.polar = pol[30:0];
        return o;
    endfunction

    task automatic report_err(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_checked = 0;
    end

    assign o_pending = sph_q.size();

    always @(posedge i_clk) begin
        t_sph got, want;
        if (!i_rst_n) begin
            mode_3d <= 1'b1;
        end else begin
            if (i_cfg_we) mode_3d <= i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) sph_q.push_back(predict_sph(i_s_tdata, mode_3d));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[94:0];
                if (sph_q.size() == 0) begin
                    // result with no point outstanding
                    report_err("unexpected radius", got.radius, 32'd0);
                end else begin
                    want = sph_q.pop_front();
                    o_checked++;
                    if (got.radius != want.radius) report_err("radius", got.radius, want.radius);
                    if (got.azimuth != want.azimuth)
                        report_err("azimuth", got.azimuth, want.azimuth);
                    if (got.polar != want.polar)
                        report_err("polar", {1'b0, got.polar}, {1'b0, want.polar});
                end
            end
        end
    end

endmodule

FILE: tb/sv/tb_cartesian_to_spherical.sv
`timescale 1ns / 1ps
// Testbench top for the spherical converter: stimulus, mode phases and the verdict.
module tb_cartesian_to_spherical;

    localparam int LATENCY = 130;
    localparam int N_RAND  = 1200;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [95:0] s_data;      // x_coord, y_coord, z_coord from bit 0 up
    logic        m_valid;
    logic        m_ready;
    logic [95:0] m_data;      // radius, azimuth, polar_angle from bit 0 up, bit 95 pad
    logic        cfg_we;
    logic        cfg_wdata;

    int n_errors, n_pending, n_checked;
    int n_sent;
    bit quiet;                // no idling in the closing stretch

    cartesian_to_spherical i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    c2s_checker i_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .i_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .i_m_tdata   (m_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (n_errors),
        .o_pending   (n_pending),
        .o_checked   (n_checked)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random stall bursts, then ready runs.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    // One request; valid stays up into the next point unless a gap is drawn.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {z, y, x};
        do @(posedge i_clk); while (!s_ready);
        n_sent++;
    endtask

    // Drain, let the pipe settle, then write the mode register while idle.
    task automatic set_mode(input logic m);
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Mixed coordinate: full range, small, zero or extreme.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2, 3:    return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [31:0] big, neg;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        quiet = 1'b0;
        n_sent = 0;
        big = 32'h7FFF_FFFF;
        neg = 32'h8000_0000;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed points in the reset mode (3D)
        send_point(0, 0, 0);                         // origin: both angles zero
        send_point(big, big, big);
        send_point(neg, neg, neg);
        send_point(32'hFFFF_0000, 0, 0);             // negative x on the axis: +pi
        send_point(neg, 0, 32'h0001_0000);
        send_point(32'h0001_0000, 0, 0);
        send_point(0, 32'h0001_0000, 0);
        send_point(0, 32'hFFFF_0000, 0);
        send_point(0, 0, 32'h0001_0000);             // polar 0
        send_point(0, 0, 32'hFFFF_0000);             // polar pi
        send_point(0, 0, 1);
        send_point(1, 1, 1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_point(big, neg, 0);
        send_point(neg, big, big);
        send_point(32'h0003_0000, 32'h0004_0000, 32'h000C_0000);

        set_mode(1'b0);                              // 2D: polar forced to zero
        send_point(0, 0, 0);
        send_point(big, big, big);
        send_point(neg, 0, neg);
        send_point(1, 1, 32'h0001_0000);

        // random phases alternating the mode
        for (int ph = 0; ph < 4; ph++) begin
            set_mode(ph[0] ? 1'b0 : 1'b1);
            for (int k = 0; k < N_RAND / 4; k++) begin
                if (ph == 3 && k > N_RAND / 4 - 150) quiet = 1'b1;
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
        end
        s_valid <= 1'b0;

        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("Sent %0d points, checked %0d results, across both mode settings.",
                 n_sent, n_checked);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
